>>> rtl/mtdf_pkg.sv
package mtdf_pkg;

  // field widths
  localparam int ID_W    = 11;
  localparam int WORD_W  = 32;
  localparam int RAW_W   = 10;
  localparam int FLAG_W  = 4;
  localparam int TEMP_W  = 8;
  localparam int VIN_W   = 11;
  localparam int IIN_W   = 10;
  localparam int VOUT_W  = 12;
  localparam int HOLD_W  = 2;
  localparam int GAIN_W  = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT0_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT1_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd2;
  localparam logic [GAIN_W-1:0]    GAIN_RESET   = 8'd8;

  localparam logic CMD_TICK = 1'b1;

  localparam logic [HOLD_W-1:0] LINK_HOLD = 2'd2;

  // serial divider: quotient bits per pass, divisor width
  localparam int QUO_W  = 12;
  localparam int DSR_W  = 8;
  localparam int DIVD_W = QUO_W + DSR_W;
  localparam int CNT_W  = $clog2(QUO_W + 1);

  // fixed-point scale factors
  localparam int K_IIN_MUL  = 87;
  localparam int K_IIN_DIV  = 100;
  localparam int K_VOUT_MUL = 21;
  localparam int K_VOUT_DIV = 10;
  localparam int TEMP_SHIFT = 3;   // temperature gain of 8

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_FILT_GO,
    ST_FILT_WAIT,
    ST_EMIT_FRAME,
    ST_TICK,
    ST_EMIT_T0,
    ST_EMIT_T1
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic in_valid;
    logic in_cmd;
    logic hit;
    logic div_done;
    logic slot_free;
  } ctl_in_t;

  typedef struct packed {
    logic in_ready;
    logic cap;
    logic scale_go;
    logic scale_take;
    logic filt_go;
    logic commit;
    logic tick_upd;
    logic emit;
    logic emit_tick;
    logic emit_last;
  } ctl_t;

endpackage

>>> rtl/mtdf_div.sv
module mtdf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mtdf_pkg::DIVD_W-1:0]   dividend,
  input  logic [mtdf_pkg::DSR_W-1:0]    divisor,
  output logic [mtdf_pkg::QUO_W-1:0]    quotient,
  output mtdf_pkg::div_stat_t           stat
);
  import mtdf_pkg::*;

  // restoring division, one quotient bit a cycle; caller keeps the
  // quotient below 2**QUO_W so the top bits seed the remainder
  logic [DSR_W-1:0] rem_r;
  logic [QUO_W-1:0] q_r;
  logic [DSR_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;
  logic [DSR_W-1:0] rem_step;

  assign trial    = {rem_r, q_r[QUO_W-1]};
  assign ge       = trial >= {1'b0, dsr_r};
  assign diff     = trial - {1'b0, dsr_r};
  assign rem_step = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DIVD_W-1:QUO_W];
      q_r   <= dividend[QUO_W-1:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_step;
      q_r   <= {q_r[QUO_W-2:0], ge};
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt  = CNT_W'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/mtdf_fsm.sv
module mtdf_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  mtdf_pkg::ctl_in_t  ci,
  output mtdf_pkg::ctl_t     ctl
);
  import mtdf_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (ci.in_valid) begin
          if (ci.in_cmd == CMD_TICK) state_nxt = ST_TICK;
          else if (ci.hit)           state_nxt = ST_SCALE_GO;
        end
      end
      ST_SCALE_GO:   state_nxt = ST_SCALE_WAIT;
      ST_SCALE_WAIT: if (ci.div_done) state_nxt = ST_FILT_GO;
      ST_FILT_GO:    state_nxt = ST_FILT_WAIT;
      ST_FILT_WAIT:  if (ci.div_done) state_nxt = ST_EMIT_FRAME;
      ST_EMIT_FRAME: if (ci.slot_free) state_nxt = ST_IDLE;
      ST_TICK:       state_nxt = ST_EMIT_T0;
      ST_EMIT_T0:    if (ci.slot_free) state_nxt = ST_EMIT_T1;
      ST_EMIT_T1:    if (ci.slot_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.cap      = ci.in_valid;
      end
      ST_SCALE_GO:   ctl.scale_go   = 1'b1;
      ST_SCALE_WAIT: ctl.scale_take = ci.div_done;
      ST_FILT_GO:    ctl.filt_go    = 1'b1;
      ST_FILT_WAIT:  ctl.commit     = ci.div_done;
      ST_EMIT_FRAME: begin
        ctl.emit      = ci.slot_free;
        ctl.emit_last = 1'b1;
      end
      ST_TICK:       ctl.tick_upd   = 1'b1;
      ST_EMIT_T0: begin
        ctl.emit      = ci.slot_free;
        ctl.emit_tick = 1'b1;
      end
      ST_EMIT_T1: begin
        ctl.emit      = ci.slot_free;
        ctl.emit_tick = 1'b1;
        ctl.emit_last = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> rtl/mppt_telemetry_decode_filter_unit.sv
// Telemetry decoder and smoother for two solar charge trackers. Each input
// item is either a CAN reply frame (cmd 0) or a one-second tick (cmd 1).
// A frame whose id equals unit 0's reply id (checked first) or unit 1's is
// decoded into that unit: flags stored, the three 10-bit readings scaled
// (vin*3/2, iin*87/100, vout*21/10, truncated) and, with the 8-bit
// temperature, smoothed by ((g-1)*old+new)/g; temperature uses g = 8, the
// rest use filter_gain (0 behaves as 1). The link hold counter reloads to
// two and one result item follows with last set. A frame matching neither
// id is taken and gives nothing. A tick counts both holds down, clears
// vin/iin/vout of a unit whose hold ends at zero, and gives two items:
// unit 0 (last clear) then unit 1 (last set). A matched frame is divided
// on three bit-serial divider lanes in two passes (scaling, then
// filtering); vin skips the scaling pass and temperature uses a shift.
// A finished item sits in the output register while the next item is
// taken. Configuration writes are always accepted.
module mppt_telemetry_decode_filter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [mtdf_pkg::ID_W-1:0]           in_msg_id,
  input  logic [mtdf_pkg::WORD_W-1:0]         in_data_a,
  input  logic [mtdf_pkg::WORD_W-1:0]         in_data_b,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_unit,
  output logic                                out_last,
  output logic                                out_battery_full,
  output logic                                out_over_temp,
  output logic                                out_no_connection,
  output logic                                out_under_volt,
  output logic [mtdf_pkg::TEMP_W-1:0]         out_temperature,
  output logic [mtdf_pkg::VIN_W-1:0]          out_volt_in,
  output logic [mtdf_pkg::IIN_W-1:0]          out_amps_in,
  output logic [mtdf_pkg::VOUT_W-1:0]         out_volt_out,
  output logic [mtdf_pkg::HOLD_W-1:0]         out_link_count,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mtdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mtdf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mtdf_pkg::*;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [ID_W-1:0]   id0_r, id1_r;
  logic [GAIN_W-1:0] gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id0_r  <= '0;
      id1_r  <= '0;
      gain_r <= GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_UNIT0_ID: id0_r  <= cfg_data[ID_W-1:0];
        REG_UNIT1_ID: id1_r  <= cfg_data[ID_W-1:0];
        REG_GAIN:     gain_r <= cfg_data[GAIN_W-1:0];
        default:      ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  ctl_in_t   ci;
  ctl_t      ctl;
  div_stat_t st_vin, st_iin, st_vout;
  logic      hit0, hit1;
  logic      out_valid_r;

  assign hit0 = (in_msg_id == id0_r);
  assign hit1 = (in_msg_id == id1_r);

  assign ci.in_valid  = in_valid;
  assign ci.in_cmd    = in_cmd;
  assign ci.hit       = hit0 | hit1;
  assign ci.div_done  = st_iin.done;   // started lanes run in lock step
  assign ci.slot_free = !out_valid_r || out_ready;

  mtdf_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .ci    (ci),
    .ctl   (ctl)
  );

  assign in_ready = ctl.in_ready;

  // ---------------------------------------------------------------
  // captured frame fields
  // ---------------------------------------------------------------
  logic              unit_r;
  logic [RAW_W-1:0]  raw_vin_r, raw_iin_r, raw_vout_r;
  logic [TEMP_W-1:0] tmp_r;
  logic [FLAG_W-1:0] flags_r;

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      unit_r     <= !hit0;
      raw_vin_r  <= {in_data_a[1:0],   in_data_a[15:8]};
      raw_iin_r  <= {in_data_a[17:16], in_data_a[31:24]};
      raw_vout_r <= {in_data_b[1:0],   in_data_b[15:8]};
      tmp_r      <= in_data_b[23:16];
      flags_r    <= in_data_a[7:4];
    end
  end

  // ---------------------------------------------------------------
  // per-unit state
  // ---------------------------------------------------------------
  logic [FLAG_W-1:0] flag_r [2];
  logic [TEMP_W-1:0] temp_r [2];
  logic [VIN_W-1:0]  vin_r  [2];
  logic [IIN_W-1:0]  iin_r  [2];
  logic [VOUT_W-1:0] vout_r [2];
  logic [HOLD_W-1:0] hold_r [2];

  // ---------------------------------------------------------------
  // divider operands
  // ---------------------------------------------------------------
  logic [GAIN_W-1:0] g_eff, gm1;
  logic [VIN_W:0]    vin_x3;
  logic [VIN_W-1:0]  smp_vin;
  logic [IIN_W-1:0]  smp_iin_r;
  logic [VOUT_W-1:0] smp_vout_r;

  logic [DIVD_W-1:0] dd_vin, dd_iin, dd_vout;
  logic [DSR_W-1:0]  dsr_filt, dsr_iin, dsr_vout;
  logic [QUO_W-1:0]  q_vin, q_iin, q_vout;

  assign g_eff = (gain_r == '0) ? GAIN_W'(1) : gain_r;
  assign gm1   = g_eff - GAIN_W'(1);

  // raw*3/2 is a shift and add, no divider pass
  assign vin_x3  = {1'b0, raw_vin_r, 1'b0} + {2'b00, raw_vin_r};
  assign smp_vin = vin_x3[VIN_W:1];

  assign dsr_filt = DSR_W'(g_eff);
  assign dsr_iin  = ctl.scale_go ? DSR_W'(K_IIN_DIV)  : dsr_filt;
  assign dsr_vout = ctl.scale_go ? DSR_W'(K_VOUT_DIV) : dsr_filt;

  // (g-1)*old + new stays below g * 2**QUO_W, so QUO_W quotient bits do
  assign dd_vin = DIVD_W'(gm1) * DIVD_W'(vin_r[unit_r]) + DIVD_W'(smp_vin);

  always_comb begin
    if (ctl.scale_go) begin
      dd_iin  = DIVD_W'(raw_iin_r)  * DIVD_W'(K_IIN_MUL);
      dd_vout = DIVD_W'(raw_vout_r) * DIVD_W'(K_VOUT_MUL);
    end else begin
      dd_iin  = DIVD_W'(gm1) * DIVD_W'(iin_r[unit_r])  + DIVD_W'(smp_iin_r);
      dd_vout = DIVD_W'(gm1) * DIVD_W'(vout_r[unit_r]) + DIVD_W'(smp_vout_r);
    end
  end

  mtdf_div u_div_vin (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.filt_go),
    .dividend (dd_vin),
    .divisor  (dsr_filt),
    .quotient (q_vin),
    .stat     (st_vin)
  );

  mtdf_div u_div_iin (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.scale_go | ctl.filt_go),
    .dividend (dd_iin),
    .divisor  (dsr_iin),
    .quotient (q_iin),
    .stat     (st_iin)
  );

  mtdf_div u_div_vout (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.scale_go | ctl.filt_go),
    .dividend (dd_vout),
    .divisor  (dsr_vout),
    .quotient (q_vout),
    .stat     (st_vout)
  );

  // scaled samples after the first pass
  always_ff @(posedge clk) begin
    if (ctl.scale_take) begin
      smp_iin_r  <= q_iin[IIN_W-1:0];
      smp_vout_r <= q_vout[VOUT_W-1:0];
    end
  end

  // temperature: gain of 8, so (7*old + new) >> 3
  logic [TEMP_W+TEMP_SHIFT-1:0] temp_sum;
  assign temp_sum = (TEMP_W+TEMP_SHIFT)'(temp_r[unit_r]) * (TEMP_W+TEMP_SHIFT)'(7)
                  + (TEMP_W+TEMP_SHIFT)'(tmp_r);

  // ---------------------------------------------------------------
  // state update: frame commit or tick countdown
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int u = 0; u < 2; u++) begin
        flag_r[u] <= '0;
        temp_r[u] <= '0;
        vin_r[u]  <= '0;
        iin_r[u]  <= '0;
        vout_r[u] <= '0;
        hold_r[u] <= '0;
      end
    end else if (ctl.commit) begin
      flag_r[unit_r] <= flags_r;
      temp_r[unit_r] <= temp_sum[TEMP_SHIFT +: TEMP_W];
      vin_r[unit_r]  <= q_vin[VIN_W-1:0];
      iin_r[unit_r]  <= q_iin[IIN_W-1:0];
      vout_r[unit_r] <= q_vout[VOUT_W-1:0];
      hold_r[unit_r] <= LINK_HOLD;
    end else if (ctl.tick_upd) begin
      for (int u = 0; u < 2; u++) begin
        if (hold_r[u] > HOLD_W'(1)) begin
          hold_r[u] <= hold_r[u] - HOLD_W'(1);
        end else begin
          // link lost: drop the electrical readings, keep flags and temp
          hold_r[u] <= '0;
          vin_r[u]  <= '0;
          iin_r[u]  <= '0;
          vout_r[u] <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  logic              eu;
  logic              out_valid_nxt;
  logic              out_unit_r, out_last_r;
  logic [FLAG_W-1:0] out_flags_r;
  logic [TEMP_W-1:0] out_temp_r;
  logic [VIN_W-1:0]  out_vin_r;
  logic [IIN_W-1:0]  out_iin_r;
  logic [VOUT_W-1:0] out_vout_r;
  logic [HOLD_W-1:0] out_hold_r;

  // a tick gives unit 0 then unit 1, so its unit equals last
  assign eu = ctl.emit_tick ? ctl.emit_last : unit_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.emit)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_unit_r  <= eu;
      out_last_r  <= ctl.emit_last;
      out_flags_r <= flag_r[eu];
      out_temp_r  <= temp_r[eu];
      out_vin_r   <= vin_r[eu];
      out_iin_r   <= iin_r[eu];
      out_vout_r  <= vout_r[eu];
      out_hold_r  <= hold_r[eu];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_unit          = out_unit_r;
  assign out_last          = out_last_r;
  assign out_battery_full  = out_flags_r[3];
  assign out_over_temp     = out_flags_r[2];
  assign out_no_connection = out_flags_r[1];
  assign out_under_volt    = out_flags_r[0];
  assign out_temperature   = out_temp_r;
  assign out_volt_in       = out_vin_r;
  assign out_amps_in       = out_iin_r;
  assign out_volt_out      = out_vout_r;
  assign out_link_count    = out_hold_r;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_lanes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.in_ready |-> !(st_vin.busy || st_iin.busy || st_vout.busy))
    else $error("divider lane busy while taking a new item");

  a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (st_vin.done && st_iin.done && st_vout.done))
    else $error("filter commit without all lanes finished");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (!out_valid_r || out_ready))
    else $error("result overwrites an item not yet taken");

  a_hold_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.commit |=> (hold_r[0] <= $past(hold_r[0])) && (hold_r[1] <= $past(hold_r[1])))
    else $error("link hold rose without a decoded frame");

  a_first_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> !out_unit_r)
    else $error("non-final item not for unit 0");

endmodule
